@@ design/tcod_pkg.sv @@
// ----------------------------------------------------------------------------
// tcod_pkg
// Shared types, constants and segment table for the timed command overlay.
// ----------------------------------------------------------------------------
`default_nettype none

package tcod_pkg;

  localparam int unsigned CMD_W    = 8;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned GLYPH_W  = 7;
  localparam int unsigned CFG_AW   = 2;
  localparam int unsigned SECS_W   = 4;
  localparam int unsigned SHOWN_W  = 8;

  // Register indexes
  localparam logic [CFG_AW-1:0] REG_HOLD_LABEL  = 2'd0;
  localparam logic [CFG_AW-1:0] REG_HOLD_TOTAL  = 2'd1;
  localparam logic [CFG_AW-1:0] REG_SHORT_TOTAL = 2'd2;

  localparam logic [CFG_W-1:0] HOLD_LABEL_RST  = 16'd750;
  localparam logic [CFG_W-1:0] HOLD_TOTAL_RST  = 16'd15000;
  localparam logic [CFG_W-1:0] SHORT_TOTAL_RST = 16'd2000;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_HOLD     = 8'h80;
  localparam logic [CMD_W-1:0] CMD_BOTH     = 8'h91;
  localparam logic [CMD_W-1:0] CMD_THROTTLE = 8'h93;
  localparam logic [CMD_W-1:0] CMD_CLUTCH   = 8'h95;

  localparam int unsigned ROUND_MS    = 1749;
  localparam int unsigned MS_PER_S    = 1000;
  localparam int unsigned MAX_SECONDS = 15;

  localparam logic [SHOWN_W-1:0] SHOWN_NONE = 8'hFF;

  localparam logic [GLYPH_W-1:0] SEG_BLANK = 7'h00;
  localparam logic [GLYPH_W-1:0] SEG_C     = 7'h39;
  localparam logic [GLYPH_W-1:0] SEG_P     = 7'h73;
  localparam logic [GLYPH_W-1:0] SEG_T     = 7'h78;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_SHORT = 2'd1,
    PH_LABEL = 2'd2,
    PH_COUNT = 2'd3
  } phase_t;

  function automatic logic [GLYPH_W-1:0] seg_digit(input logic [SECS_W-1:0] d);
    logic [GLYPH_W-1:0] g;
    case (d)
      4'd0: g = 7'h3f;
      4'd1: g = 7'h06;
      4'd2: g = 7'h5b;
      4'd3: g = 7'h4f;
      4'd4: g = 7'h66;
      4'd5: g = 7'h6d;
      4'd6: g = 7'h7d;
      4'd7: g = 7'h07;
      4'd8: g = 7'h7f;
      4'd9: g = 7'h6f;
      default: g = SEG_BLANK;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

@@ design/tcod_if.sv @@
// ----------------------------------------------------------------------------
// tcod channel interfaces
// Input item, result and configuration write channels, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcod_item_if;
  import tcod_pkg::*;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [CMD_W-1:0]  command;
  logic [TIME_W-1:0] now_ms;
  modport source (output valid, kind, command, now_ms, input ready);
  modport sink   (input valid, kind, command, now_ms, output ready);
endinterface

interface tcod_result_if;
  import tcod_pkg::*;
  logic               valid;
  logic               ready;
  logic               changed;
  logic [GLYPH_W-1:0] glyph_left;
  logic [GLYPH_W-1:0] glyph_middle;
  logic [GLYPH_W-1:0] glyph_right;
  logic               owns_display;
  logic [1:0]         phase_now;
  modport source (output valid, changed, glyph_left, glyph_middle, glyph_right,
                  owns_display, phase_now, input ready);
  modport sink   (input valid, changed, glyph_left, glyph_middle, glyph_right,
                  owns_display, phase_now, output ready);
endinterface

interface tcod_cfg_if;
  import tcod_pkg::*;
  logic              valid;
  logic              ready;
  logic [CFG_AW-1:0] addr;
  logic [CFG_W-1:0]  data;
  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

`default_nettype wire

@@ design/tcod_countdown.sv @@
// ----------------------------------------------------------------------------
// tcod_countdown
// Whole-second countdown value and its digit glyphs from remaining time.
// ----------------------------------------------------------------------------
`default_nettype none

module tcod_countdown (
  input  wire logic [tcod_pkg::TIME_W-1:0]  remain,
  output logic      [tcod_pkg::SECS_W-1:0]  secs,
  output logic      [tcod_pkg::GLYPH_W-1:0] glyph_tens,
  output logic      [tcod_pkg::GLYPH_W-1:0] glyph_ones
);
  import tcod_pkg::*;

  localparam int unsigned LOW_W  = 14;
  localparam int unsigned RND_W  = LOW_W + 1;
  localparam int unsigned SAT_MS = MAX_SECONDS * MS_PER_S - ROUND_MS;

  logic             saturate;
  logic [RND_W-1:0] rounded;
  logic [SECS_W-1:0] q;

  assign saturate = (|remain[TIME_W-1:LOW_W]) ||
                    ({1'b0, remain[LOW_W-1:0]} >= RND_W'(SAT_MS));
  assign rounded  = {1'b0, remain[LOW_W-1:0]} + RND_W'(ROUND_MS);

  // quotient below the cap: count thresholds passed
  always_comb begin
    q = '0;
    for (int k = 1; k < MAX_SECONDS; k++) begin
      q = q + SECS_W'(rounded >= RND_W'(k * MS_PER_S));
    end
  end

  assign secs = saturate ? SECS_W'(MAX_SECONDS) : q;

  always_comb begin
    if (secs >= 4'd10) begin
      glyph_tens = seg_digit(4'd1);
      glyph_ones = seg_digit(secs - 4'd10);
    end else begin
      glyph_tens = SEG_BLANK;
      glyph_ones = seg_digit(secs);
    end
  end

endmodule

`default_nettype wire

@@ design/timed_command_overlay_display.sv @@
// ----------------------------------------------------------------------------
// timed_command_overlay_display
// Three-position seven-segment overlay driven by commands and ms time.
// ----------------------------------------------------------------------------
// Channels: item (kind, command, now_ms) in, result (changed, glyphs,
// owns_display, phase_now) out, both valid/ready; cfg writes the three
// timing registers by addr/data and is always ready.
// Each accepted word yields one result word. From input accept to result
// valid, a word passes the input register, then the state update and
// result register load in the same cycle. Throughput is one word per cycle
// while the receiver takes results; the state loop (display state read
// and written through one compare/countdown stage) closes through the
// display state registers alone. A new word is taken while a result waits,
// as long as the input register is free or moving on in that cycle.
// Reset (rst, synchronous) empties both registers, clears the display
// state to idle/blank and restores the timing registers to 750, 15000 and
// 2000 ms. When the receiver stalls, the result word holds and the input
// register fills; item.ready then drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module timed_command_overlay_display (
  input  wire logic   clk,
  input  wire logic   rst,
  tcod_item_if.sink   item,
  tcod_result_if.source result,
  tcod_cfg_if.sink    cfg
);
  import tcod_pkg::*;

  // configuration
  logic [CFG_W-1:0] hold_label_ms;
  logic [CFG_W-1:0] hold_total_ms;
  logic [CFG_W-1:0] short_total_ms;

  // input register
  logic              s1_valid;
  logic              s1_kind;
  logic [CMD_W-1:0]  s1_cmd;
  logic [TIME_W-1:0] s1_now;

  // display state, also the result word
  logic               out_valid;
  logic               changed;
  logic [CMD_W-1:0]   stored_command;
  logic [SHOWN_W-1:0] shown_seconds;
  logic               busy;
  logic [TIME_W-1:0]  label_until;
  logic [TIME_W-1:0]  end_time;
  phase_t             phase_reg;
  logic [GLYPH_W-1:0] glyph_store [3];

  logic               changed_next;
  logic [CMD_W-1:0]   stored_command_next;
  logic [SHOWN_W-1:0] shown_seconds_next;
  logic               busy_next;
  logic [TIME_W-1:0]  label_until_next;
  logic [TIME_W-1:0]  end_time_next;
  phase_t             phase_next;
  logic [GLYPH_W-1:0] glyph_next [3];

  logic              advance;
  logic [TIME_W-1:0] end_diff;
  logic [TIME_W-1:0] label_diff;
  logic [TIME_W-1:0] remain;
  logic              end_reached;
  logic              label_reached;
  logic [SECS_W-1:0]  secs;
  logic [GLYPH_W-1:0] glyph_tens;
  logic [GLYPH_W-1:0] glyph_ones;

  assign advance    = s1_valid && (!out_valid || result.ready);
  assign item.ready = !s1_valid || advance;
  assign cfg.ready  = 1'b1;

  assign end_diff      = s1_now - end_time;
  assign label_diff    = s1_now - label_until;
  assign remain        = end_time - s1_now;
  assign end_reached   = !end_diff[TIME_W-1];
  assign label_reached = !label_diff[TIME_W-1];

  tcod_countdown u_countdown (
    .remain     (remain),
    .secs       (secs),
    .glyph_tens (glyph_tens),
    .glyph_ones (glyph_ones)
  );

  always_comb begin
    changed_next        = 1'b0;
    stored_command_next = stored_command;
    shown_seconds_next  = shown_seconds;
    busy_next           = busy;
    label_until_next    = label_until;
    end_time_next       = end_time;
    phase_next          = phase_reg;
    glyph_next          = glyph_store;
    if (s1_kind) begin
      stored_command_next = s1_cmd;
      shown_seconds_next  = SHOWN_NONE;
      busy_next           = 1'b1;
      changed_next        = 1'b1;
      if (s1_cmd == CMD_HOLD) begin
        label_until_next = s1_now + TIME_W'(hold_label_ms);
        end_time_next    = s1_now + TIME_W'(hold_total_ms);
        phase_next       = PH_LABEL;
        glyph_next       = '{SEG_P, SEG_P, SEG_C};
      end else begin
        label_until_next = '0;
        end_time_next    = s1_now + TIME_W'(short_total_ms);
        phase_next       = PH_SHORT;
        case (s1_cmd)
          CMD_BOTH:     glyph_next = '{SEG_C, SEG_BLANK, SEG_T};
          CMD_THROTTLE: glyph_next = '{SEG_BLANK, SEG_T, SEG_BLANK};
          CMD_CLUTCH:   glyph_next = '{SEG_BLANK, SEG_C, SEG_BLANK};
          default:      glyph_next = '{SEG_BLANK, SEG_BLANK, SEG_BLANK};
        endcase
      end
    end else if (busy) begin
      if (end_reached) begin
        glyph_next   = '{SEG_BLANK, SEG_BLANK, SEG_BLANK};
        phase_next   = PH_IDLE;
        busy_next    = 1'b0;
        changed_next = 1'b1;
      end else if (stored_command == CMD_HOLD && label_reached) begin
        if (!(phase_reg == PH_COUNT && shown_seconds == SHOWN_W'(secs))) begin
          glyph_next         = '{SEG_BLANK, glyph_tens, glyph_ones};
          shown_seconds_next = SHOWN_W'(secs);
          phase_next         = PH_COUNT;
          changed_next       = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_label_ms  <= HOLD_LABEL_RST;
      hold_total_ms  <= HOLD_TOTAL_RST;
      short_total_ms <= SHORT_TOTAL_RST;
    end else if (cfg.valid) begin
      case (cfg.addr)
        REG_HOLD_LABEL:  hold_label_ms  <= cfg.data;
        REG_HOLD_TOTAL:  hold_total_ms  <= cfg.data;
        REG_SHORT_TOTAL: short_total_ms <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.ready && item.valid) begin
      s1_kind <= item.kind;
      s1_cmd  <= item.command;
      s1_now  <= item.now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      changed        <= 1'b0;
      stored_command <= '0;
      shown_seconds  <= '0;
      busy           <= 1'b0;
      label_until    <= '0;
      end_time       <= '0;
      phase_reg      <= PH_IDLE;
      glyph_store    <= '{SEG_BLANK, SEG_BLANK, SEG_BLANK};
    end else if (advance) begin
      out_valid      <= 1'b1;
      changed        <= changed_next;
      stored_command <= stored_command_next;
      shown_seconds  <= shown_seconds_next;
      busy           <= busy_next;
      label_until    <= label_until_next;
      end_time       <= end_time_next;
      phase_reg      <= phase_next;
      glyph_store    <= glyph_next;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign result.valid        = out_valid;
  assign result.changed      = changed;
  assign result.glyph_left   = glyph_store[0];
  assign result.glyph_middle = glyph_store[1];
  assign result.glyph_right  = glyph_store[2];
  assign result.owns_display = busy;
  assign result.phase_now    = phase_reg;

endmodule

`default_nettype wire

@@ design/tcod_checker.sv @@
// ----------------------------------------------------------------------------
// tcod_checker
// Port-level checks on the overlay result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tcod_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire logic                            changed,
  input wire logic [tcod_pkg::GLYPH_W-1:0]    glyph_left,
  input wire logic [tcod_pkg::GLYPH_W-1:0]    glyph_middle,
  input wire logic [tcod_pkg::GLYPH_W-1:0]    glyph_right,
  input wire logic                            owns_display,
  input wire logic [1:0]                      phase_now
);
  import tcod_pkg::*;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(changed) &&
      $stable(glyph_left) && $stable(glyph_middle) && $stable(glyph_right) &&
      $stable(owns_display) && $stable(phase_now))
    else $error("result word changed while stalled");

  a_owns_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (owns_display == (phase_now != PH_IDLE)))
    else $error("ownership disagrees with phase");

  a_idle_blank: assert property (@(posedge clk) disable iff (rst)
    out_valid && !owns_display |->
      glyph_left == SEG_BLANK && glyph_middle == SEG_BLANK && glyph_right == SEG_BLANK)
    else $error("glyphs lit while idle");

  a_count_left_blank: assert property (@(posedge clk) disable iff (rst)
    out_valid && phase_now == PH_COUNT |-> glyph_left == SEG_BLANK &&
      glyph_right != SEG_BLANK)
    else $error("bad countdown glyphs");

endmodule

bind timed_command_overlay_display tcod_checker u_tcod_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .changed      (result.changed),
  .glyph_left   (result.glyph_left),
  .glyph_middle (result.glyph_middle),
  .glyph_right  (result.glyph_right),
  .owns_display (result.owns_display),
  .phase_now    (result.phase_now)
);

`default_nettype wire
